// ===== rtl/vnorm_pkg.sv =====
// Shared types for the vector normalizer pipeline.
`timescale 1ns / 1ps
package vnorm_pkg;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

// ===== rtl/vector3_normalize_with_gain.sv =====
// Top level: scales a 3D vector to the magnitude given by gain.
// Throughput: one word per cycle unless a stall on the output holds the pipeline.
// The square root takes COMP_WIDTH + 1 stages and each component divider
// COMP_WIDTH + 1 stages, one result bit per computing stage.
// A stall on the output holds every stage; rst clears all valid bits.
`timescale 1ns / 1ps
module vector3_normalize_with_gain #(
  parameter int COMP_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] vec_x,
  input  logic signed [COMP_WIDTH-1:0] vec_y,
  input  logic signed [COMP_WIDTH-1:0] vec_z,
  input  logic signed [COMP_WIDTH-1:0] gain,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] unit_x,
  output logic signed [COMP_WIDTH-1:0] unit_y,
  output logic signed [COMP_WIDTH-1:0] unit_z,
  output logic                         degenerate
);
  import vnorm_pkg::*;

  localparam int W = COMP_WIDTH;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] mx;
    logic [W-1:0] my;
    logic [W-1:0] mz;
    logic [W-1:0] mg;
    logic         sx;
    logic         sy;
    logic         sz;
    logic         sg;
    logic         deg;
  } side_t;

  typedef struct packed {
    logic nx;
    logic ny;
    logic nz;
    logic deg;
  } sign_t;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic                v_in, v_a, v_b, v_c, v_p, v_n;
  logic signed [W-1:0] rx, ry, rz, rg;
  side_t               sa, sb, sc;
  logic [2*W-1:0]      qx, qy, qz, sq_sum;
  side_t               sd [W+1];
  logic [W-1:0]        len, len_p;
  logic                len_vld;
  logic [2*W-1:0]      px, py, pz, numx, numy, numz;
  logic [W-1:0]        den;
  sign_t               sp, sn;
  sign_t               dd [W+1];
  logic [W-1:0]        quox, quoy, quoz;
  logic                ovx, ovy, ovz, dvld;
  pipe_ctl_t           sqrt_ctl, div_ctl;

  assign sqrt_ctl = '{adv: adv, vld: v_c};
  assign div_ctl  = '{adv: adv, vld: v_n};

  function automatic logic [W-1:0] sat_out(logic [W-1:0] q, logic ov, logic neg);
    if (neg) begin
      return (ov || q > MIN_NEG) ? MIN_NEG : (~q + 1'b1);
    end
    return (ov || q[W-1]) ? MAX_POS : q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in      <= 1'b0;
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_p       <= 1'b0;
      v_n       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_in      <= in_valid;
      v_a       <= v_in;
      v_b       <= v_a;
      v_c       <= v_b;
      v_p       <= len_vld;
      v_n       <= v_p;
      out_valid <= dvld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx <= vec_x;
      ry <= vec_y;
      rz <= vec_z;
      rg <= gain;

      sa.mx  <= rx[W-1] ? (~rx + 1'b1) : rx;
      sa.my  <= ry[W-1] ? (~ry + 1'b1) : ry;
      sa.mz  <= rz[W-1] ? (~rz + 1'b1) : rz;
      sa.mg  <= rg[W-1] ? (~rg + 1'b1) : rg;
      sa.sx  <= rx[W-1];
      sa.sy  <= ry[W-1];
      sa.sz  <= rz[W-1];
      sa.sg  <= rg[W-1];
      sa.deg <= (rx == '0) && (ry == '0) && (rz == '0);

      qx <= (2*W)'(sa.mx) * (2*W)'(sa.mx);
      qy <= (2*W)'(sa.my) * (2*W)'(sa.my);
      qz <= (2*W)'(sa.mz) * (2*W)'(sa.mz);
      sb <= sa;

      sq_sum <= qx + qy + qz;
      sc     <= sb;

      sd[0] <= sc;
      for (int k = 1; k <= W; k++) begin
        sd[k] <= sd[k-1];
      end

      px     <= (2*W)'(sd[W].mx) * (2*W)'(sd[W].mg);
      py     <= (2*W)'(sd[W].my) * (2*W)'(sd[W].mg);
      pz     <= (2*W)'(sd[W].mz) * (2*W)'(sd[W].mg);
      len_p  <= len;
      sp.nx  <= sd[W].sx ^ sd[W].sg;
      sp.ny  <= sd[W].sy ^ sd[W].sg;
      sp.nz  <= sd[W].sz ^ sd[W].sg;
      sp.deg <= sd[W].deg;

      numx <= px + (2*W)'(len_p >> 1);
      numy <= py + (2*W)'(len_p >> 1);
      numz <= pz + (2*W)'(len_p >> 1);
      den  <= len_p;
      sn   <= sp;

      dd[0] <= sn;
      for (int k = 1; k <= W; k++) begin
        dd[k] <= dd[k-1];
      end

      unit_x     <= dd[W].deg ? '0 : sat_out(quox, ovx, dd[W].nx);
      unit_y     <= dd[W].deg ? '0 : sat_out(quoy, ovy, dd[W].ny);
      unit_z     <= dd[W].deg ? '0 : sat_out(quoz, ovz, dd[W].nz);
      degenerate <= dd[W].deg;
    end
  end

  vnorm_sqrt #(.W(W)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sqrt_ctl),
    .sq_sum  (sq_sum),
    .len     (len),
    .len_vld (len_vld)
  );

  vnorm_div #(.W(W)) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .num     (numx),
    .den     (den),
    .quo     (quox),
    .ovf     (ovx),
    .quo_vld (dvld)
  );

  vnorm_div #(.W(W)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .num     (numy),
    .den     (den),
    .quo     (quoy),
    .ovf     (ovy),
    .quo_vld ()
  );

  vnorm_div #(.W(W)) u_div_z (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .num     (numz),
    .den     (den),
    .quo     (quoz),
    .ovf     (ovz),
    .quo_vld ()
  );

endmodule

// ===== rtl/vnorm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, rounded to nearest.
`timescale 1ns / 1ps
module vnorm_sqrt #(
  parameter int W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vnorm_pkg::pipe_ctl_t  ctl,
  input  logic [2*W-1:0]        sq_sum,
  output logic [W-1:0]          len,
  output logic                  len_vld
);
  import vnorm_pkg::*;

  localparam int RW = W + 2;

  logic [RW-1:0]  rem     [W];
  logic [W-1:0]   root    [W];
  logic [2*W-1:0] rest    [W];
  logic [W-1:0]   vld;
  logic [RW-1:0]  rem_next  [W];
  logic [W-1:0]   root_next [W];
  logic [2*W-1:0] rest_next [W];

  always_comb begin
    logic [RW-1:0]  prem;
    logic [W-1:0]   proot;
    logic [2*W-1:0] prest;
    logic [RW+1:0]  sh;
    logic [RW+1:0]  trial;
    logic [RW+1:0]  diff;
    for (int k = 0; k < W; k++) begin
      if (k == 0) begin
        prem  = '0;
        proot = '0;
        prest = sq_sum;
      end else begin
        prem  = rem[k-1];
        proot = root[k-1];
        prest = rest[k-1];
      end
      sh    = {prem, prest[2*W-1 -: 2]};
      trial = {2'b00, proot, 2'b01};
      diff  = sh - trial;
      if (!diff[RW+1]) begin
        rem_next[k]  = diff[RW-1:0];
        root_next[k] = {proot[W-2:0], 1'b1};
      end else begin
        rem_next[k]  = sh[RW-1:0];
        root_next[k] = {proot[W-2:0], 1'b0};
      end
      rest_next[k] = {prest[2*W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      len_vld <= 1'b0;
    end else if (ctl.adv) begin
      vld     <= {vld[W-2:0], ctl.vld};
      len_vld <= vld[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < W; k++) begin
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        rest[k] <= rest_next[k];
      end
      len <= root[W-1] + W'(rem[W-1] > {2'b00, root[W-1]});
    end
  end

endmodule

// ===== rtl/vnorm_div.sv =====
// Pipelined rounded-numerator divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module vnorm_div #(
  parameter int W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vnorm_pkg::pipe_ctl_t  ctl,
  input  logic [2*W-1:0]        num,
  input  logic [W-1:0]          den,
  output logic [W-1:0]          quo,
  output logic                  ovf,
  output logic                  quo_vld
);
  import vnorm_pkg::*;

  logic [W-1:0] r   [W+1];
  logic [W-1:0] lo  [W+1];
  logic [W-1:0] d   [W+1];
  logic [W-1:0] q   [W+1];
  logic [W:0]   ov;
  logic [W:0]   vld;
  logic [W-1:0] r_next [W+1];
  logic         bit_next [W+1];

  always_comb begin
    logic [W:0]   sh;
    logic [W+1:0] diff;
    r_next[0]   = '0;
    bit_next[0] = 1'b0;
    for (int k = 1; k <= W; k++) begin
      sh   = {r[k-1], lo[k-1][W-1]};
      diff = {1'b0, sh} - {2'b00, d[k-1]};
      if (!diff[W+1]) begin
        r_next[k]   = diff[W-1:0];
        bit_next[k] = 1'b1;
      end else begin
        r_next[k]   = sh[W-1:0];
        bit_next[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.adv) begin
      vld <= {vld[W-1:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      r[0]  <= num[2*W-1:W];
      lo[0] <= num[W-1:0];
      d[0]  <= den;
      q[0]  <= '0;
      ov[0] <= num >= {den, {W{1'b0}}};
      for (int k = 1; k <= W; k++) begin
        r[k]  <= r_next[k];
        lo[k] <= {lo[k-1][W-2:0], 1'b0};
        d[k]  <= d[k-1];
        q[k]  <= {q[k-1][W-2:0], bit_next[k]};
        ov[k] <= ov[k-1];
      end
    end
  end

  assign quo     = q[W];
  assign ovf     = ov[W];
  assign quo_vld = vld[W];

endmodule
